FILE: sv/tpba_pkg.sv
// Package for the two-pool bitmap block allocator: sizes, codes, the
// fit-search result struct and the map geometry constants.
// No dependencies; every other file but tpba_ram refers to it by scoped names.
package tpba_pkg;

   // Map geometry
   localparam int SMALL_WORDS = 64;
   localparam int LARGE_WORDS = 16;
   localparam int SMALL_AW    = (SMALL_WORDS > 1) ? $clog2(SMALL_WORDS) : 1;
   localparam int LARGE_AW    = (LARGE_WORDS > 1) ? $clog2(LARGE_WORDS) : 1;
   localparam int MAX_AW      = (SMALL_AW > LARGE_AW) ? SMALL_AW : LARGE_AW;
   localparam int WORD_BITS   = 32;
   localparam int BIT_W       = 5;

   // Field widths
   localparam int SIZE_W   = 24;
   localparam int POOL_W   = 2;
   localparam int STATUS_W = 2;
   localparam int HANDLE_W = 32;
   localparam int POS_W    = 16;
   localparam int COUNT_W  = 16;
   localparam int OFFSET_W = 22;
   localparam int THRESH_W = 16;
   localparam int NEED_W   = 5;
   localparam int WIDX_W   = 11;

   // Constants
   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'h3200;
   localparam logic [HANDLE_W-1:0] NO_HANDLE    = 32'hFFFF_FFFF;
   localparam int SMALL_SHIFT  = 9;             // 512-byte blocks
   localparam int LARGE_RATIO  = 5;             // 2560 = 5 * 512
   localparam int RECIP5       = 205;           // floor(x / 5) = (x * 205) >> 10, x < 1024
   localparam int RECIP_SHIFT  = 10;
   localparam int RUN_LIMIT    = 32;            // runs this long go to the general heap
   localparam logic [SIZE_W-1:0] LARGE_HEAP_SIZE = 24'd79360;  // 31 * 2560

   // Request codes
   typedef enum logic {
      REQ_TAKE = 1'b0,
      REQ_FREE = 1'b1
   } req_type_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 2'd0,
      ST_HEAP = 2'd1,
      ST_FAIL = 2'd2
   } status_type;

   // Pool codes
   typedef enum logic [POOL_W-1:0] {
      POOL_NONE  = 2'd0,
      POOL_SMALL = 2'd1,
      POOL_LARGE = 2'd2,
      POOL_HEAP  = 2'd3
   } pool_type;

   // First-fit result for one map word
   typedef struct packed {
      logic                 found;
      logic [BIT_W-1:0]     bit_pos;
      logic [WORD_BITS-1:0] set_mask;
   } fit_type;

endpackage

FILE: sv/tpba_if.sv
// Channel interfaces of the block allocator: request, response and
// configuration write. Widths come from tpba_pkg.
interface tpba_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [tpba_pkg::SIZE_W-1:0]   size_bytes;
   logic [tpba_pkg::POOL_W-1:0]   prev_pool;
   logic [tpba_pkg::HANDLE_W-1:0] handle_in;

   modport source (output valid, req_type, size_bytes, prev_pool, handle_in, input ready);
   modport sink   (input valid, req_type, size_bytes, prev_pool, handle_in, output ready);
endinterface

interface tpba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpba_pkg::STATUS_W-1:0] status;
   logic [tpba_pkg::POOL_W-1:0]   pool_out;
   logic [tpba_pkg::HANDLE_W-1:0] handle_out;
   logic [tpba_pkg::OFFSET_W-1:0] byte_offset;

   modport source (output valid, status, pool_out, handle_out, byte_offset, input ready);
   modport sink   (input valid, status, pool_out, handle_out, byte_offset, output ready);
endinterface

interface tpba_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tpba_pkg::THRESH_W-1:0] large_first_threshold;

   modport source (output valid, large_first_threshold, input ready);
   modport sink   (input valid, large_first_threshold, output ready);
endinterface

FILE: sv/tpba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module tpba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tpba_fit.sv
// First-fit search for a run of clear bits inside one 32-bit map word.
// Depends on tpba_pkg for widths and the fit_type result struct.
module tpba_fit (
   input  logic [tpba_pkg::WORD_BITS-1:0] map_word,
   input  logic [tpba_pkg::NEED_W-1:0]    need,
   output tpba_pkg::fit_type              fit
);

   logic [tpba_pkg::WORD_BITS-1:0] ones;
   logic [tpba_pkg::WORD_BITS-1:0] hit;
   logic                           full;

   // Check every start position, then take the lowest one that fits
   always_comb begin
      ones = (32'h1 << need) - 32'h1;
      full = &map_word;
      for (int j = 0; j < tpba_pkg::WORD_BITS; j++) begin
         hit[j] = (((map_word >> j) & ones) == '0) &&
                  ((6'(j) + {1'b0, need}) <= 6'(tpba_pkg::WORD_BITS)) && !full;
      end
      fit.found   = |hit;
      fit.bit_pos = '0;
      for (int j = tpba_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (hit[j]) begin
            fit.bit_pos = tpba_pkg::BIT_W'(j);
         end
      end
      fit.set_mask = ones << fit.bit_pos;
   end

endmodule

FILE: sv/two_pool_bitmap_block_allocator.sv
// Two-pool bitmap block allocator, top level.
// Depends on tpba_pkg, tpba_if, tpba_ram and tpba_fit.
//
// Usage:
//   req_bus carries one word per take or free request; rsp_bus returns one
//   result word per request; csr_bus writes large_first_threshold and is
//   always ready. Write it only while no request is in flight.
//   The two pool bitmaps sit in two RAMs with registered reads.
//   A take searches map words one per cycle, first fit inside each word,
//   the preferred pool first and then the other when allowed.
// Sequence:
//   take: work out run lengths, then scan the map words of the preferred
//   pool and, when allowed, of the other; at most SMALL_WORDS +
//   LARGE_WORDS (80 here) words are scanned. When the first pool tried
//   needs 32 or more blocks the take ends as a heap result without a
//   scan. free: read, check, write back, or refused early before the read.
//   One request is in work at a time; req_bus is ready only when idle.
//   The scan loop over the RAM read port sets how long a take lasts.
// Reset: synchronous, active high. Both maps read as all free right after
//   reset through per-word valid bits; the threshold returns to 12800.
// Stall: a finished result waits in the output register while the next
//   request is accepted and worked; that request's result holds in the
//   block until rsp_bus takes the earlier one.
module two_pool_bitmap_block_allocator (
   input  logic        clock,
   input  logic        reset,
   tpba_req_if.sink    req_bus,
   tpba_rsp_if.source  rsp_bus,
   tpba_csr_if.sink    csr_bus
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_TRY,
      S_SCAN,
      S_FREE,
      S_FREE_CHK,
      S_OUT
   } state_type;

   localparam int SAW = tpba_pkg::SMALL_AW;
   localparam int LAW = tpba_pkg::LARGE_AW;
   localparam int MAW = tpba_pkg::MAX_AW;
   localparam int WB  = tpba_pkg::WORD_BITS;

   // Control registers
   state_type                         state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tpba_pkg::THRESH_W-1:0]     thresh_ff, thresh_in;
   logic [tpba_pkg::SMALL_WORDS-1:0]  small_vld_ff, small_vld_in;
   logic [tpba_pkg::LARGE_WORDS-1:0]  large_vld_ff, large_vld_in;

   // Request and search registers
   logic [tpba_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic [tpba_pkg::POOL_W-1:0]       prev_ff, prev_in;
   logic [tpba_pkg::HANDLE_W-1:0]     hin_ff, hin_in;
   logic [tpba_pkg::NEED_W-1:0]       need_s_ff, need_s_in;
   logic [tpba_pkg::NEED_W-1:0]       need_l_ff, need_l_in;
   logic                              heap_s_ff, heap_s_in;
   logic                              heap_l_ff, heap_l_in;
   logic                              large_ff, large_in;
   logic                              second_ff, second_in;
   logic [MAW-1:0]                    addr_ff, addr_in;
   logic                              vs_rd_ff, vs_rd_in;
   logic                              vl_rd_ff, vl_rd_in;

   // Result staging and output registers
   tpba_pkg::status_type              res_status_ff, res_status_in;
   logic [tpba_pkg::POOL_W-1:0]       res_pool_ff, res_pool_in;
   logic [tpba_pkg::HANDLE_W-1:0]     res_handle_ff, res_handle_in;
   logic [tpba_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [tpba_pkg::POOL_W-1:0]       rsp_pool_ff, rsp_pool_in;
   logic [tpba_pkg::HANDLE_W-1:0]     rsp_handle_ff, rsp_handle_in;
   logic [tpba_pkg::OFFSET_W-1:0]     rsp_offset_ff, rsp_offset_in;

   // RAM ports
   logic                              rd_en;
   logic [MAW-1:0]                    rd_addr;
   logic                              wr_en_s, wr_en_l;
   logic [WB-1:0]                     wr_data;
   logic [WB-1:0]                     s_rdata, l_rdata;

   // Datapath
   logic [WB-1:0]                     cur_word;
   logic [tpba_pkg::NEED_W-1:0]       cur_need;
   logic                              cur_heap;
   logic [MAW-1:0]                    last_addr;
   tpba_pkg::fit_type                 fit;
   logic [tpba_pkg::SIZE_W:0]         round_sum;
   logic [tpba_pkg::COUNT_W-1:0]      need_s_full;
   logic [7:0]                        need_q;
   logic [15:0]                       need_prod;
   logic [tpba_pkg::WIDX_W-1:0]       free_word;
   logic                              free_in_range;
   logic [tpba_pkg::COUNT_W-1:0]      free_count;
   logic [WB:0]                       free_ones;
   logic [WB-1:0]                     free_mask;
   logic [tpba_pkg::POS_W-1:0]        res_pos;
   logic [tpba_pkg::OFFSET_W-1:0]     off_small, off_large;

   // Pool maps
   tpba_ram #(.WIDTH(WB), .DEPTH(tpba_pkg::SMALL_WORDS)) u_small_ram (
      .clock   (clock),
      .wr_en   (wr_en_s),
      .wr_addr (SAW'(addr_ff)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (SAW'(rd_addr)),
      .rd_data (s_rdata)
   );

   tpba_ram #(.WIDTH(WB), .DEPTH(tpba_pkg::LARGE_WORDS)) u_large_ram (
      .clock   (clock),
      .wr_en   (wr_en_l),
      .wr_addr (LAW'(addr_ff)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (LAW'(rd_addr)),
      .rd_data (l_rdata)
   );

   // Select the word and run length of the pool in work
   always_comb begin
      cur_word  = large_ff ? (vl_rd_ff ? l_rdata : '0) : (vs_rd_ff ? s_rdata : '0);
      cur_need  = large_ff ? need_l_ff : need_s_ff;
      cur_heap  = large_ff ? heap_l_ff : heap_s_ff;
      last_addr = large_ff ? MAW'(tpba_pkg::LARGE_WORDS - 1) :
                             MAW'(tpba_pkg::SMALL_WORDS - 1);
   end

   tpba_fit u_fit (
      .map_word (cur_word),
      .need     (cur_need),
      .fit      (fit)
   );

   // Run lengths: ceil(size/512), and ceil(size/2560) as ceil(that/5)
   always_comb begin
      round_sum   = {1'b0, size_ff} + (tpba_pkg::SIZE_W+1)'((1 << tpba_pkg::SMALL_SHIFT) - 1);
      need_s_full = tpba_pkg::COUNT_W'(round_sum >> tpba_pkg::SMALL_SHIFT);
      need_q      = need_s_full[7:0] + 8'd4;
      need_prod   = 16'(need_q) * 16'(tpba_pkg::RECIP5);
   end

   // Free run shape and range check
   always_comb begin
      free_word     = hin_ff[tpba_pkg::WIDX_W+tpba_pkg::BIT_W-1:tpba_pkg::BIT_W];
      free_in_range = (prev_ff == tpba_pkg::POOL_LARGE) ?
                      ({1'b0, free_word} < 12'(tpba_pkg::LARGE_WORDS)) :
                      ({1'b0, free_word} < 12'(tpba_pkg::SMALL_WORDS));
      free_count    = hin_ff[tpba_pkg::HANDLE_W-1:tpba_pkg::POS_W];
      free_ones     = (free_count >= 16'(tpba_pkg::RUN_LIMIT)) ? {1'b0, {WB{1'b1}}} :
                      ((33'h1 << free_count[tpba_pkg::BIT_W-1:0]) - 33'h1);
      free_mask     = free_ones[WB-1:0] << hin_ff[tpba_pkg::BIT_W-1:0];
   end

   // Byte offset of a taken run
   always_comb begin
      res_pos   = res_handle_ff[tpba_pkg::POS_W-1:0];
      off_small = tpba_pkg::OFFSET_W'(res_pos) << tpba_pkg::SMALL_SHIFT;
      off_large = (tpba_pkg::OFFSET_W'(res_pos) *
                   tpba_pkg::OFFSET_W'(tpba_pkg::LARGE_RATIO)) << tpba_pkg::SMALL_SHIFT;
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      thresh_in     = csr_bus.valid ? csr_bus.large_first_threshold : thresh_ff;
      small_vld_in  = small_vld_ff;
      large_vld_in  = large_vld_ff;
      size_in       = size_ff;
      prev_in       = prev_ff;
      hin_in        = hin_ff;
      need_s_in     = need_s_ff;
      need_l_in     = need_l_ff;
      heap_s_in     = heap_s_ff;
      heap_l_in     = heap_l_ff;
      large_in      = large_ff;
      second_in     = second_ff;
      addr_in       = addr_ff;
      vs_rd_in      = vs_rd_ff;
      vl_rd_in      = vl_rd_ff;
      res_status_in = res_status_ff;
      res_pool_in   = res_pool_ff;
      res_handle_in = res_handle_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pool_in   = rsp_pool_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_offset_in = rsp_offset_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en_s       = 1'b0;
      wr_en_l       = 1'b0;
      wr_data       = '0;

      unique case (state_ff)
         S_IDLE: begin
            // Take one request word
            if (req_bus.valid) begin
               size_in     = req_bus.size_bytes;
               prev_in     = req_bus.prev_pool;
               hin_in      = req_bus.handle_in;
               state_in    = (req_bus.req_type == tpba_pkg::REQ_FREE) ? S_FREE : S_PREP;
            end
         end
         S_PREP: begin
            // Work out run lengths and pool order
            need_s_in = need_s_full[tpba_pkg::NEED_W-1:0];
            heap_s_in = (need_s_full >= 16'(tpba_pkg::RUN_LIMIT));
            need_l_in = tpba_pkg::NEED_W'(need_prod >> tpba_pkg::RECIP_SHIFT);
            heap_l_in = (size_ff > tpba_pkg::LARGE_HEAP_SIZE);
            if (prev_ff == tpba_pkg::POOL_SMALL) begin
               large_in  = 1'b1;
               second_in = 1'b0;
            end else if (prev_ff == tpba_pkg::POOL_LARGE) begin
               large_in  = 1'b0;
               second_in = 1'b0;
            end else begin
               large_in  = ({8'b0, size_ff} > 32'(thresh_ff));
               second_in = 1'b1;
            end
            state_in = S_TRY;
         end
         S_TRY: begin
            // Send oversized runs to the heap, else start the scan at word 0
            if (cur_heap) begin
               res_status_in = tpba_pkg::ST_HEAP;
               res_pool_in   = tpba_pkg::POOL_HEAP;
               res_handle_in = tpba_pkg::NO_HANDLE;
               state_in      = S_OUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               addr_in  = '0;
               vs_rd_in = small_vld_ff[SAW'(rd_addr)];
               vl_rd_in = large_vld_ff[LAW'(rd_addr)];
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Check the word just read; claim the run or read the next word
            if (fit.found) begin
               wr_data = cur_word | fit.set_mask;
               if (large_ff) begin
                  wr_en_l = 1'b1;
                  large_vld_in[LAW'(addr_ff)] = 1'b1;
                  res_pool_in = tpba_pkg::POOL_LARGE;
               end else begin
                  wr_en_s = 1'b1;
                  small_vld_in[SAW'(addr_ff)] = 1'b1;
                  res_pool_in = tpba_pkg::POOL_SMALL;
               end
               res_status_in = tpba_pkg::ST_DONE;
               res_handle_in = {tpba_pkg::COUNT_W'(cur_need),
                                tpba_pkg::POS_W'({addr_ff, fit.bit_pos})};
               state_in      = S_OUT;
            end else if (addr_ff == last_addr) begin
               if (second_ff) begin
                  large_in  = !large_ff;
                  second_in = 1'b0;
                  state_in  = S_TRY;
               end else begin
                  res_status_in = tpba_pkg::ST_FAIL;
                  res_pool_in   = tpba_pkg::POOL_NONE;
                  res_handle_in = tpba_pkg::NO_HANDLE;
                  state_in      = S_OUT;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = addr_ff + MAW'(1);
               addr_in  = rd_addr;
               vs_rd_in = small_vld_ff[SAW'(rd_addr)];
               vl_rd_in = large_vld_ff[LAW'(rd_addr)];
            end
         end
         S_FREE: begin
            // Screen the handle, then read its map word
            large_in = (prev_ff == tpba_pkg::POOL_LARGE);
            if (prev_ff != tpba_pkg::POOL_SMALL && prev_ff != tpba_pkg::POOL_LARGE) begin
               res_status_in = tpba_pkg::ST_HEAP;
               res_pool_in   = prev_ff;
               res_handle_in = hin_ff;
               state_in      = S_OUT;
            end else if (hin_ff == tpba_pkg::NO_HANDLE || !free_in_range) begin
               res_status_in = tpba_pkg::ST_FAIL;
               res_pool_in   = prev_ff;
               res_handle_in = hin_ff;
               state_in      = S_OUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = MAW'(free_word);
               addr_in  = rd_addr;
               vs_rd_in = small_vld_ff[SAW'(rd_addr)];
               vl_rd_in = large_vld_ff[LAW'(rd_addr)];
               state_in = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            // Clear the run only if every bit of it is set
            if ((cur_word & free_mask) == free_mask) begin
               wr_data = cur_word & ~free_mask;
               if (large_ff) begin
                  wr_en_l = 1'b1;
                  large_vld_in[LAW'(addr_ff)] = 1'b1;
               end else begin
                  wr_en_s = 1'b1;
                  small_vld_in[SAW'(addr_ff)] = 1'b1;
               end
               res_status_in = tpba_pkg::ST_DONE;
               res_pool_in   = tpba_pkg::POOL_NONE;
               res_handle_in = tpba_pkg::NO_HANDLE;
            end else begin
               res_status_in = tpba_pkg::ST_FAIL;
               res_pool_in   = prev_ff;
               res_handle_in = hin_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pool_in   = res_pool_ff;
               rsp_handle_in = res_handle_ff;
               if (res_status_ff == tpba_pkg::ST_DONE && res_pool_ff == tpba_pkg::POOL_SMALL) begin
                  rsp_offset_in = off_small;
               end else if (res_status_ff == tpba_pkg::ST_DONE &&
                            res_pool_ff == tpba_pkg::POOL_LARGE) begin
                  rsp_offset_in = off_large;
               end else begin
                  rsp_offset_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         thresh_ff    <= tpba_pkg::THRESH_RESET;
         small_vld_ff <= '0;
         large_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         thresh_ff    <= thresh_in;
         small_vld_ff <= small_vld_in;
         large_vld_ff <= large_vld_in;
      end
      size_ff       <= size_in;
      prev_ff       <= prev_in;
      hin_ff        <= hin_in;
      need_s_ff     <= need_s_in;
      need_l_ff     <= need_l_in;
      heap_s_ff     <= heap_s_in;
      heap_l_ff     <= heap_l_in;
      large_ff      <= large_in;
      second_ff     <= second_in;
      addr_ff       <= addr_in;
      vs_rd_ff      <= vs_rd_in;
      vl_rd_ff      <= vl_rd_in;
      res_status_ff <= res_status_in;
      res_pool_ff   <= res_pool_in;
      res_handle_ff <= res_handle_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pool_ff   <= rsp_pool_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // Ports
   assign req_bus.ready       = (state_ff == S_IDLE);
   assign csr_bus.ready       = 1'b1;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.pool_out    = rsp_pool_ff;
   assign rsp_bus.handle_out  = rsp_handle_ff;
   assign rsp_bus.byte_offset = rsp_offset_ff;

endmodule

FILE: sv/tpba_checker.sv
// Port-level checker for the block allocator, bound to the top level.
// Depends on tpba_pkg for field widths and result codes.
module tpba_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tpba_pkg::STATUS_W-1:0] rsp_status,
   input logic [tpba_pkg::POOL_W-1:0]   rsp_pool_out,
   input logic [tpba_pkg::HANDLE_W-1:0] rsp_handle_out,
   input logic [tpba_pkg::OFFSET_W-1:0] rsp_byte_offset
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status) &&
      $stable(rsp_pool_out) && $stable(rsp_handle_out) && $stable(rsp_byte_offset)))
      else $error("stalled result word changed");

   // One request in work: drop ready right after an accept
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   // Only a placed take carries an offset
   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != tpba_pkg::ST_DONE || rsp_pool_out == tpba_pkg::POOL_NONE))
      |-> (rsp_byte_offset == '0))
      else $error("offset given for a result without a placed run");

   // Heap results name no pool or the general heap
   a_heap_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tpba_pkg::ST_HEAP) |->
      (rsp_pool_out == tpba_pkg::POOL_NONE || rsp_pool_out == tpba_pkg::POOL_HEAP))
      else $error("heap result with a bitmap pool");

   // A finished free leaves no handle
   a_free_handle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tpba_pkg::ST_DONE && rsp_pool_out == tpba_pkg::POOL_NONE)
      |-> (rsp_handle_out == tpba_pkg::NO_HANDLE))
      else $error("finished free returned a handle");

endmodule

bind two_pool_bitmap_block_allocator tpba_checker u_tpba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_pool_out    (rsp_bus.pool_out),
   .rsp_handle_out  (rsp_bus.handle_out),
   .rsp_byte_offset (rsp_bus.byte_offset)
);

FILE: tb/sv/tb.sv
// Testbench for the two-pool bitmap block allocator: directed and random
// take/free traffic checked against a bitmap predictor, with random stalls.
// Depends on tpba_pkg, tpba_if and the two_pool_bitmap_block_allocator RTL.
`timescale 1ns / 100ps

module tb;

   localparam int SMALL_BLOCK  = 512;
   localparam int LARGE_BLOCK  = 2560;
   localparam int DRAIN_CYCLES = 8;
   localparam int TAIL_CYCLES  = 90;

   typedef struct {
      tpba_pkg::req_type_type      kind;
      logic [tpba_pkg::SIZE_W-1:0] size;
      tpba_pkg::pool_type          prev;
      logic [31:0]                 handle;
   } alloc_req_type;

   typedef struct {
      tpba_pkg::status_type          status;
      tpba_pkg::pool_type            pool;
      logic [31:0]                   handle;
      logic [tpba_pkg::OFFSET_W-1:0] offset;
   } alloc_result_type;

   typedef struct {
      tpba_pkg::pool_type pool;
      logic [31:0]        handle;
   } live_run_type;

   logic clock;
   logic reset;

   tpba_req_if req_bus ();
   tpba_rsp_if rsp_bus ();
   tpba_csr_if csr_bus ();

   two_pool_bitmap_block_allocator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Predicted bitmaps and threshold
   logic [31:0]      small_bits [tpba_pkg::SMALL_WORDS];
   logic [31:0]      large_bits [tpba_pkg::LARGE_WORDS];
   logic [15:0]      threshold_model;

   alloc_result_type pending_outcomes [$];
   live_run_type     live_runs [$];
   int               errors;
   int               burst_left;
   bit               pacing;
   int               hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // First fit of a run of clear bits inside one map word; mark it used
   function automatic bit first_fit(tpba_pkg::pool_type pool, int unsigned need,
                                    output int unsigned pos);
      int unsigned words;
      int unsigned i;
      int unsigned j;
      logic [31:0] w;
      logic [31:0] run;
      words = (pool == tpba_pkg::POOL_SMALL) ? tpba_pkg::SMALL_WORDS : tpba_pkg::LARGE_WORDS;
      pos = 0;
      for (i = 0; i < words; i++) begin
         w = (pool == tpba_pkg::POOL_SMALL) ? small_bits[i] : large_bits[i];
         if (w == 32'hFFFF_FFFF)
            continue;
         run = (32'd1 << need) - 32'd1;
         for (j = 0; j <= 32 - need; j++) begin
            if ((w & run) == 32'd0) begin
               if (pool == tpba_pkg::POOL_SMALL)
                  small_bits[i] = w | run;
               else
                  large_bits[i] = w | run;
               pos = i * 32 + j;
               return 1'b1;
            end
            run = run << 1;
         end
      end
      return 1'b0;
   endfunction

   // Work out the result word of one request and update the bitmaps
   function automatic alloc_result_type bitmap_outcome(alloc_req_type rq);
      alloc_result_type   res;
      tpba_pkg::pool_type order [2];
      tpba_pkg::pool_type pool;
      int unsigned        sz, need_s, need_l, need, tries, t, pos, p, bs, words;
      int unsigned        count, widx;
      logic [63:0]        run64;
      logic [31:0]        mask, w, off;
      res = '{tpba_pkg::ST_FAIL, tpba_pkg::POOL_NONE, tpba_pkg::NO_HANDLE, '0};
      if (rq.kind == tpba_pkg::REQ_TAKE) begin
         sz = 32'(rq.size);
         need_s = (sz + SMALL_BLOCK - 1) / SMALL_BLOCK;
         need_l = (sz + LARGE_BLOCK - 1) / LARGE_BLOCK;
         if (rq.prev == tpba_pkg::POOL_SMALL) begin
            order[0] = tpba_pkg::POOL_LARGE;
            tries = 1;
         end else if (rq.prev == tpba_pkg::POOL_LARGE) begin
            order[0] = tpba_pkg::POOL_SMALL;
            tries = 1;
         end else begin
            order[0] = (sz > threshold_model) ? tpba_pkg::POOL_LARGE : tpba_pkg::POOL_SMALL;
            order[1] = (order[0] == tpba_pkg::POOL_LARGE) ? tpba_pkg::POOL_SMALL :
                                                             tpba_pkg::POOL_LARGE;
            tries = 2;
         end
         for (t = 0; t < tries; t++) begin
            pool = order[t];
            need = (pool == tpba_pkg::POOL_SMALL) ? need_s : need_l;
            if (need >= tpba_pkg::RUN_LIMIT) begin
               res = '{tpba_pkg::ST_HEAP, tpba_pkg::POOL_HEAP, tpba_pkg::NO_HANDLE, '0};
               return res;
            end
            if (first_fit(pool, need, pos)) begin
               p = pos & 32'hFFFF;
               bs = (pool == tpba_pkg::POOL_SMALL) ? SMALL_BLOCK : LARGE_BLOCK;
               off = p * bs;
               res.status = tpba_pkg::ST_DONE;
               res.pool = pool;
               res.handle = (need << 16) | p;
               res.offset = off[tpba_pkg::OFFSET_W-1:0];
               return res;
            end
         end
         return res;
      end
      // Free: heap pools pass through, bad handles leave the maps alone
      if (rq.prev != tpba_pkg::POOL_SMALL && rq.prev != tpba_pkg::POOL_LARGE) begin
         res = '{tpba_pkg::ST_HEAP, rq.prev, rq.handle, '0};
         return res;
      end
      res = '{tpba_pkg::ST_FAIL, rq.prev, rq.handle, '0};
      if (rq.handle == tpba_pkg::NO_HANDLE)
         return res;
      count = 32'(rq.handle[31:16]);
      if (count > 32)
         count = 32;
      widx = 32'(rq.handle[15:5]);
      run64 = ((64'd1 << count) - 64'd1) << rq.handle[4:0];
      mask = run64[31:0];
      words = (rq.prev == tpba_pkg::POOL_SMALL) ? tpba_pkg::SMALL_WORDS :
                                                  tpba_pkg::LARGE_WORDS;
      if (widx >= words)
         return res;
      w = (rq.prev == tpba_pkg::POOL_SMALL) ? small_bits[widx] : large_bits[widx];
      if ((w & mask) != mask)
         return res;
      if (rq.prev == tpba_pkg::POOL_SMALL)
         small_bits[widx] = w & ~mask;
      else
         large_bits[widx] = w & ~mask;
      res = '{tpba_pkg::ST_DONE, tpba_pkg::POOL_NONE, tpba_pkg::NO_HANDLE, '0};
      return res;
   endfunction

   function automatic alloc_req_type make_req(tpba_pkg::req_type_type kind,
                                              int unsigned size,
                                              tpba_pkg::pool_type prev,
                                              logic [31:0] handle);
      alloc_req_type rq;
      rq.kind = kind;
      rq.size = size[tpba_pkg::SIZE_W-1:0];
      rq.prev = prev;
      rq.handle = handle;
      return rq;
   endfunction

   function automatic logic [31:0] run_handle(int unsigned count, int unsigned word,
                                              int unsigned first);
      return {count[15:0], word[10:0], first[4:0]};
   endfunction

   task automatic report_error(string msg);
      $display("check: %s", msg);
      errors++;
   endtask

   // Offer one request word, predict it on accept, then idle per the burst pattern
   task automatic send_item(alloc_req_type rq);
      alloc_result_type res;
      int               gap;
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= rq.kind;
      req_bus.size_bytes <= rq.size;
      req_bus.prev_pool  <= rq.prev;
      req_bus.handle_in  <= rq.handle;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      res = bitmap_outcome(rq);
      pending_outcomes.push_back(res);
      if (rq.kind == tpba_pkg::REQ_TAKE && res.status == tpba_pkg::ST_DONE)
         live_runs.push_back('{res.pool, res.handle});
      if (pacing) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
               5, 6, 7:       gap = $urandom_range(4, 12);
               8:             gap = $urandom_range(30, 100);
               default:       gap = 0;
            endcase
            burst_left = $urandom_range(1, 16);
            if (gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   task automatic take(int unsigned size, tpba_pkg::pool_type prev);
      send_item(make_req(tpba_pkg::REQ_TAKE, size, prev, $urandom));
   endtask

   task automatic release_run(tpba_pkg::pool_type prev, logic [31:0] handle);
      send_item(make_req(tpba_pkg::REQ_FREE, $urandom_range(0, 24'hFFFFFF), prev, handle));
   endtask

   // Hold the sender until every result word is back
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(logic [15:0] value);
      wait_drain();
      csr_bus.valid                 <= 1'b1;
      csr_bus.large_first_threshold <= value;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      threshold_model = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic free_all_live();
      live_run_type e;
      while (live_runs.size() != 0) begin
         e = live_runs.pop_front();
         release_run(e.pool, e.handle);
      end
      wait_drain();
   endtask

   // Check each result word against the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_error($sformatf("result word with nothing expected, handle %h",
                                   rsp_bus.handle_out));
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.status !== want.status)
               report_error($sformatf("status got %0d want %0d",
                                      rsp_bus.status, want.status));
            if (rsp_bus.pool_out !== want.pool)
               report_error($sformatf("pool_out got %0d want %0d",
                                      rsp_bus.pool_out, want.pool));
            if (rsp_bus.handle_out !== want.handle)
               report_error($sformatf("handle_out got %h want %h",
                                      rsp_bus.handle_out, want.handle));
            if (rsp_bus.byte_offset !== want.offset)
               report_error($sformatf("byte_offset got %h want %h",
                                      rsp_bus.byte_offset, want.offset));
         end
      end
   end

   // Receiver stall pattern; a requested hold keeps ready low until the hold count runs out
   initial begin
      int hold_left;
      int stall_pct;
      int mode_left;
      hold_left = 0;
      stall_pct = 0;
      mode_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 20;
               2:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Take sizes at the block-count edges, every pool order, heap cases
   task automatic test_take_sizes();
      take(0, tpba_pkg::POOL_NONE);
      take(1, tpba_pkg::POOL_NONE);
      take(512, tpba_pkg::POOL_NONE);
      take(513, tpba_pkg::POOL_NONE);
      take(12800, tpba_pkg::POOL_NONE);
      take(12801, tpba_pkg::POOL_NONE);
      take(15872, tpba_pkg::POOL_LARGE);
      take(15873, tpba_pkg::POOL_LARGE);
      take(79360, tpba_pkg::POOL_SMALL);
      take(79361, tpba_pkg::POOL_SMALL);
      take(24'hFFFFFF, tpba_pkg::POOL_NONE);
      take(3000, tpba_pkg::POOL_HEAP);
      take(0, tpba_pkg::POOL_SMALL);
      wait_drain();
   endtask

   // Good, double, heap, no-handle and out-of-range frees
   task automatic test_free_cases();
      live_run_type e;
      take(1024, tpba_pkg::POOL_NONE);
      wait_drain();
      e = live_runs.pop_back();
      release_run(e.pool, e.handle);
      release_run(e.pool, e.handle);
      release_run(tpba_pkg::POOL_NONE, $urandom);
      release_run(tpba_pkg::POOL_HEAP, tpba_pkg::NO_HANDLE);
      release_run(tpba_pkg::POOL_SMALL, tpba_pkg::NO_HANDLE);
      release_run(tpba_pkg::POOL_LARGE, run_handle(1, tpba_pkg::LARGE_WORDS, 0));
      release_run(tpba_pkg::POOL_SMALL, run_handle(2, 0, 30));
      wait_drain();
   endtask

   // Threshold extremes move the pool order
   task automatic test_threshold_extremes();
      set_threshold(16'd0);
      take(0, tpba_pkg::POOL_NONE);
      take(1, tpba_pkg::POOL_NONE);
      set_threshold(16'hFFFF);
      take(65535, tpba_pkg::POOL_NONE);
      take(65536, tpba_pkg::POOL_NONE);
      take(0, tpba_pkg::POOL_HEAP);
      set_threshold(tpba_pkg::THRESH_RESET);
   endtask

   // Fill both pools until takes fail, then exercise free run shapes on full words
   task automatic test_pool_exhaustion();
      free_all_live();
      repeat (tpba_pkg::SMALL_WORDS + 1) take(31 * SMALL_BLOCK, tpba_pkg::POOL_LARGE);
      take(0, tpba_pkg::POOL_LARGE);
      repeat (tpba_pkg::SMALL_WORDS) take(1, tpba_pkg::POOL_LARGE);
      take(0, tpba_pkg::POOL_LARGE);
      take(1024, tpba_pkg::POOL_NONE);
      repeat (tpba_pkg::LARGE_WORDS + 1) take(31 * LARGE_BLOCK, tpba_pkg::POOL_SMALL);
      repeat (10) take(15872, tpba_pkg::POOL_NONE);
      // saturate an oversized count and drop the bits above the word
      release_run(tpba_pkg::POOL_SMALL, run_handle(16'hFFFF, 3, 1));
      release_run(tpba_pkg::POOL_SMALL, run_handle(0, 5, 7));
      release_run(tpba_pkg::POOL_SMALL, run_handle(16'hFFFF, 3, 1));
      wait_drain();
      free_all_live();
   endtask

   // Stall the receiver for a long stretch while requests keep coming
   task automatic test_backpressure();
      hold_request = 300;
      @(posedge clock);
      pacing = 1'b0;
      repeat (12) take($urandom_range(0, 4000), tpba_pkg::POOL_NONE);
      pacing = 1'b1;
      wait_drain();
   endtask

   // Mostly take/free of live runs with random sizes, some noise requests
   task automatic test_random_traffic();
      live_run_type       e;
      int                 idx;
      int unsigned        size;
      tpba_pkg::pool_type prev;
      logic [15:0]        phase_threshold [4];
      phase_threshold[0] = 16'hFFFF;
      phase_threshold[1] = 16'd0;
      phase_threshold[2] = 16'($urandom_range(0, 65535));
      phase_threshold[3] = 16'($urandom_range(2000, 20000));
      for (int ph = 0; ph < 4; ph++) begin
         set_threshold(phase_threshold[ph]);
         repeat (65) begin
            idx = $urandom_range(0, 99);
            if (live_runs.size() > 120)
               idx = 60;
            if (idx < 50) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: size = $urandom_range(0, 4 * SMALL_BLOCK);
                  5, 6:          size = $urandom_range(0, 16000);
                  7:             size = $urandom_range(0, 80000);
                  8:             size = $urandom_range(0, 24'hFFFFFF);
                  default: begin
                     case ($urandom_range(0, 3))
                        0:       size = 15872;
                        1:       size = 79360;
                        2:       size = 32'(threshold_model);
                        default: size = 32'(threshold_model) + 1;
                     endcase
                  end
               endcase
               case ($urandom_range(0, 9))
                  0:       prev = tpba_pkg::POOL_SMALL;
                  1:       prev = tpba_pkg::POOL_LARGE;
                  2:       prev = tpba_pkg::POOL_HEAP;
                  default: prev = tpba_pkg::POOL_NONE;
               endcase
               take(size, prev);
            end else if (idx < 88 && live_runs.size() != 0) begin
               idx = $urandom_range(0, live_runs.size() - 1);
               e = live_runs[idx];
               live_runs.delete(idx);
               release_run(e.pool, e.handle);
            end else begin
               send_item(make_req(tpba_pkg::req_type_type'($urandom_range(0, 1)),
                                  $urandom_range(0, 24'hFFFFFF),
                                  tpba_pkg::pool_type'($urandom_range(0, 3)), $urandom));
            end
         end
      end
      wait_drain();
   endtask

   initial begin
      errors       = 0;
      burst_left   = 0;
      pacing       = 1'b1;
      hold_request = 0;
      req_bus.valid                 <= 1'b0;
      req_bus.req_type              <= tpba_pkg::REQ_TAKE;
      req_bus.size_bytes            <= '0;
      req_bus.prev_pool             <= tpba_pkg::POOL_NONE;
      req_bus.handle_in             <= '0;
      csr_bus.valid                 <= 1'b0;
      csr_bus.large_first_threshold <= '0;
      reset                         <= 1'b1;
      for (int i = 0; i < tpba_pkg::SMALL_WORDS; i++)
         small_bits[i] = '0;
      for (int i = 0; i < tpba_pkg::LARGE_WORDS; i++)
         large_bits[i] = '0;
      threshold_model = tpba_pkg::THRESH_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_take_sizes();
      test_free_cases();
      test_threshold_extremes();
      test_pool_exhaustion();
      test_backpressure();
      test_random_traffic();

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_error($sformatf("%0d result words never arrived",
                                pending_outcomes.size()));
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
